// File: design/lkd_pkg.sv
// Shared types, register indexes and constants for the ladder key debouncer.
package lkd_pkg;

    localparam int unsigned KEY_W          = 5;
    localparam int unsigned TIME_W         = 32;
    localparam int unsigned ADC_W          = 10;
    localparam int unsigned PERIOD_W       = 8;
    localparam int unsigned LONG_W         = 16;
    localparam int unsigned CFG_DATA_W     = 16;
    localparam int unsigned HISTORY_DEPTH_DEF = 4;

    localparam logic [TIME_W-1:0]   GUARD_MS          = 32'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_MS_RESET   = 8'd10;
    localparam logic [LONG_W-1:0]   LONG_PRESS_RESET  = 16'd1000;

    localparam logic CMD_POLL  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic CFG_PERIOD_MS     = 1'b0;
    localparam logic CFG_LONG_PRESS_MS = 1'b1;

    localparam logic [KEY_W-1:0] KEY_NONE = 5'b00000;
    localparam logic [KEY_W-1:0] KEY_A    = 5'b00001;
    localparam logic [KEY_W-1:0] KEY_B    = 5'b00100;
    localparam logic [KEY_W-1:0] KEY_C    = 5'b01000;
    localparam logic [KEY_W-1:0] KEY_D    = 5'b00010;
    localparam logic [KEY_W-1:0] KEY_E    = 5'b10000;

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] now_ms;
        logic [ADC_W-1:0]  adc_sample;
    } t_in_item;

    typedef struct packed {
        logic             release_event;
        logic [KEY_W-1:0] long_keys;
        logic [KEY_W-1:0] stable_mask;
        logic [KEY_W-1:0] previous_mask;
        logic [KEY_W-1:0] changed_mask;
        logic             any_pressed;
    } t_out_item;

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] now_ms;
        logic [KEY_W-1:0]  raw_keys;
    } t_stage;

endpackage

// File: design/lkd_ladder.sv
// Ladder voltage to one-hot key mask decoder.
module lkd_ladder (
    input  logic [lkd_pkg::ADC_W-1:0] i_adc_sample,
    output logic [lkd_pkg::KEY_W-1:0] o_keys
);
    import lkd_pkg::*;

    always_comb begin
        if (i_adc_sample < 10'd100) begin
            o_keys = KEY_A;
        end else if (i_adc_sample < 10'd200) begin
            o_keys = KEY_B;
        end else if (i_adc_sample >= 10'd300 && i_adc_sample < 10'd400) begin
            o_keys = KEY_C;
        end else if (i_adc_sample >= 10'd500 && i_adc_sample < 10'd600) begin
            o_keys = KEY_D;
        end else if (i_adc_sample >= 10'd700 && i_adc_sample < 10'd800) begin
            o_keys = KEY_E;
        end else begin
            o_keys = KEY_NONE;
        end
    end

endmodule

// File: design/lkd_core.sv
// Debounce state, long-press timing and result formation for one transaction.
module lkd_core #(
    parameter int unsigned HISTORY_DEPTH = lkd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [lkd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_step,
    input  lkd_pkg::t_stage                i_stage,
    output lkd_pkg::t_out_item             o_result
);
    import lkd_pkg::*;

    localparam int unsigned SLOT_W = $clog2(HISTORY_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

    logic [KEY_W-1:0]    r_history [HISTORY_DEPTH];
    logic [SLOT_W-1:0]   r_write_slot;
    logic [KEY_W-1:0]    r_stable_keys, n_stable_keys;
    logic [KEY_W-1:0]    r_prior_keys, n_prior_keys;
    logic [KEY_W-1:0]    r_delta_keys, n_delta_keys;
    logic [TIME_W-1:0]   r_press_start, n_press_start;
    logic [TIME_W-1:0]   r_next_sample, n_next_sample;
    logic                r_release_wait, n_release_wait;
    logic [PERIOD_W-1:0] r_period_ms;
    logic [LONG_W-1:0]   r_long_press_ms;

    logic [KEY_W-1:0]  acc;
    logic [TIME_W-1:0] held;
    logic              is_long;
    logic              blocked;
    logic              sample;
    logic              rel;
    logic [KEY_W-1:0]  lng;

    assign held    = i_stage.now_ms - r_press_start;
    assign is_long = (r_press_start != '0) && (held > {16'd0, r_long_press_ms});
    assign blocked = r_release_wait && ((r_prior_keys & i_stage.raw_keys) != '0);
    assign sample  = (i_stage.command == CMD_POLL) && !blocked &&
                     (i_stage.now_ms >= r_next_sample);

    always_comb begin
        acc = i_stage.raw_keys;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (SLOT_W'(i) != r_write_slot) begin
                acc = acc & r_history[i];
            end
        end
    end

    always_comb begin
        n_stable_keys  = r_stable_keys;
        n_prior_keys   = r_prior_keys;
        n_delta_keys   = r_delta_keys;
        n_press_start  = r_press_start;
        n_next_sample  = r_next_sample;
        n_release_wait = r_release_wait;
        rel            = 1'b0;
        lng            = KEY_NONE;
        if (i_stage.command == CMD_QUERY) begin
            if (is_long) begin
                n_next_sample = i_stage.now_ms + GUARD_MS;
                lng           = r_prior_keys;
            end
            n_press_start = '0;
        end else begin
            if (r_release_wait && !blocked) begin
                n_release_wait = 1'b0;
            end
            if (sample) begin
                n_prior_keys  = r_stable_keys;
                n_stable_keys = acc;
                n_delta_keys  = acc ^ r_stable_keys;
                n_next_sample = i_stage.now_ms + {24'd0, r_period_ms};
                if (n_delta_keys != '0 && n_delta_keys == acc) begin
                    n_press_start = i_stage.now_ms;
                end else if (n_delta_keys == '0 && acc != '0 && is_long) begin
                    n_delta_keys   = acc;
                    n_stable_keys  = '0;
                    n_release_wait = 1'b1;
                end
                rel = (n_delta_keys != '0) && (n_stable_keys == '0);
            end
        end
    end

    always_comb begin
        o_result.release_event = rel;
        o_result.long_keys     = lng;
        o_result.stable_mask   = n_stable_keys;
        o_result.previous_mask = n_prior_keys;
        o_result.changed_mask  = n_delta_keys;
        o_result.any_pressed   = (n_stable_keys != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_history[i] <= '0;
            end
            r_write_slot    <= '0;
            r_stable_keys   <= '0;
            r_prior_keys    <= '0;
            r_delta_keys    <= '0;
            r_press_start   <= '0;
            r_next_sample   <= '0;
            r_release_wait  <= 1'b0;
            r_period_ms     <= PERIOD_MS_RESET;
            r_long_press_ms <= LONG_PRESS_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PERIOD_MS:     r_period_ms     <= i_cfg_data[PERIOD_W-1:0];
                    CFG_LONG_PRESS_MS: r_long_press_ms <= i_cfg_data[LONG_W-1:0];
                    default:           r_period_ms     <= r_period_ms;
                endcase
            end
            if (i_step) begin
                if (sample) begin
                    r_history[r_write_slot] <= i_stage.raw_keys;
                    r_write_slot <= (r_write_slot == SLOT_LAST) ? '0 : r_write_slot + 1'b1;
                end
                r_stable_keys  <= n_stable_keys;
                r_prior_keys   <= n_prior_keys;
                r_delta_keys   <= n_delta_keys;
                r_press_start  <= n_press_start;
                r_next_sample  <= n_next_sample;
                r_release_wait <= n_release_wait;
            end
        end
    end

    a_wait_means_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_release_wait |-> (r_stable_keys == '0))
        else $error("release wait with nonzero stable mask");

    a_delta_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_delta_keys == (r_stable_keys ^ r_prior_keys))
        else $error("changed mask out of step with stable and previous masks");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_slot <= SLOT_LAST)
        else $error("history write slot out of range");

    a_query_clears_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_stage.command == CMD_QUERY) |=> (r_press_start == '0))
        else $error("press start kept after query");

endmodule

// File: design/ladder_key_debounce_long_press.sv
// Top level: input stage, debounce core and result register with handshakes.
// One transaction per clock sustained while the output is taken: the ladder
// reading is decoded into the input register, then the debounce core updates
// its state in one pass and loads the result register, which offers it on
// o_out_valid. Throughput is set by the single state update per cycle in the
// core; a stalled result register holds the input stage, and both stages
// drain as soon as o_out_valid is taken.
// Configuration writes are always accepted and take effect the next cycle.
module ladder_key_debounce_long_press #(
    parameter int unsigned HISTORY_DEPTH = lkd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lkd_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lkd_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [lkd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lkd_pkg::*;

    logic       r_in_vld;
    t_stage     r_stage;
    logic       r_out_vld;
    t_out_item  r_out_item;
    t_out_item  result;
    logic [KEY_W-1:0] raw_keys;
    logic       advance;

    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    lkd_ladder u_ladder (
        .i_adc_sample (i_in_item.adc_sample),
        .o_keys       (raw_keys)
    );

    lkd_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (advance),
        .i_stage     (r_stage),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_stage.command  <= i_in_item.command;
            r_stage.now_ms   <= i_in_item.now_ms;
            r_stage.raw_keys <= raw_keys;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |-> !advance)
        else $error("result register overwritten while stalled");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> r_in_vld)
        else $error("input stage dropped a transaction");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld)
        else $error("processed transaction produced no result");

endmodule
